/* rtl/cht_pkg.sv */
// Package for the chained hash table engine: sizes, operation codes, state type.
// No dependencies.
`timescale 1ns / 1ps
package cht_pkg;
   localparam int NumBucketsDefault = 251;
   localparam int NumNodesDefault   = 256;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_NODE_RD,
      ST_NODE_CHK,
      ST_UPDATE,
      ST_DONE
   } state_type;
endpackage

/* rtl/cht_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`timescale 1ns / 1ps
interface cht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] key;
   logic [31:0] tag;
   logic [31:0] record;
   modport source (output valid, operation, key, tag, record, input ready);
   modport sink   (input valid, operation, key, tag, record, output ready);
endinterface

interface cht_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        already_present;
   logic [31:0] found_record;
   modport source (output valid, status, already_present, found_record, input ready);
   modport sink   (input valid, status, already_present, found_record, output ready);
endinterface

/* rtl/chained_hash_table_engine.sv */
// Chained hash table engine: top level with bucket, node and free-stack memories.
// Depends on cht_pkg and the channel interfaces in cht_if.sv.
//
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | operation, key, tag, record
//  rsp     | out | valid/ready        | status, already_present, found_record
//
// One item at a time through the walk, which reads and checks each node in turn
// (ST_NODE_RD, ST_NODE_CHK) until a match or the end of the chain; the unused
// operation code leaves at ST_NODE_RD. The bucket comes from a reciprocal multiply
// and one correcting subtract in ST_HASH, ST_MOD and ST_HEAD_RD.
// After reset a clearing pass empties the bucket heads.
// The result waits in an output register; the next item is taken meanwhile and
// holds in its last state until that result is gone.
`timescale 1ns / 1ps
module chained_hash_table_engine #(
   parameter int NUM_BUCKETS = cht_pkg::NumBucketsDefault,
   parameter int NUM_NODES   = cht_pkg::NumNodesDefault
) (
   input logic       clock,
   input logic       reset,
   cht_req_if.sink   req,
   cht_rsp_if.source rsp
);
   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int NW = $clog2(NUM_NODES);
   localparam int PW = NW + 1;                 // node pointer incl. nil
   localparam int RW = $clog2(NUM_BUCKETS) + 1; // remainder width
   localparam logic [PW-1:0] NIL = PW'(NUM_NODES);
   // The quotient estimate is low by at most one, so one subtract corrects it.
   localparam int SH = 31 + BW;
   localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(NUM_BUCKETS);

   // Memories.
   logic [PW-1:0] head_mem [NUM_BUCKETS];
   logic [31:0]   key_mem  [NUM_NODES];
   logic [31:0]   tag_mem  [NUM_NODES];
   logic [31:0]   rec_mem  [NUM_NODES];
   logic [PW-1:0] link_mem [NUM_NODES];
   logic [NW-1:0] stk_mem  [NUM_NODES];

   cht_pkg::state_type state_ff, state_in;
   cht_pkg::op_type    op_ff, op_in;
   logic [31:0]   key_ff, key_in, tag_ff, tag_in, rec_ff, rec_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [63:0]   prod_ff, prod_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [PW-1:0] cur_ff, cur_in, prv_ff, prv_in;
   logic [PW:0]   steps_ff, steps_in;
   logic [PW-1:0] rcnt_ff, rcnt_in, fcnt_ff, fcnt_in;
   logic          rv_ff, rv_in, st_ff, st_in, dup_ff, dup_in;
   logic [31:0]   fr_ff, fr_in;
   logic          ost_ff, ost_in, odup_ff, odup_in;
   logic [31:0]   ofr_ff, ofr_in;

   // Memory ports.
   logic          hw_en;  logic [BW-1:0] hw_a;  logic [PW-1:0] hw_d;
   logic [BW-1:0] hr_a;   logic [PW-1:0] hr_q;
   logic          nw_en;  logic [NW-1:0] nw_a;
   logic          lw_en;  logic [NW-1:0] lw_a;  logic [PW-1:0] lw_d;
   logic [NW-1:0] nr_a;
   logic [31:0]   k_q, t_q, r_q;  logic [PW-1:0] l_q;
   logic          sw_en;  logic [NW-1:0] sw_a;  logic [NW-1:0] sw_d;
   logic [NW-1:0] sr_a;   logic [NW-1:0] s_q;

   always_ff @(posedge clock) begin
      if (hw_en) begin
         head_mem[hw_a] <= hw_d;
      end
      hr_q <= head_mem[hr_a];
      if (nw_en) begin
         key_mem[nw_a] <= key_ff;
         tag_mem[nw_a] <= tag_ff;
         rec_mem[nw_a] <= rec_ff;
      end
      if (lw_en) begin
         link_mem[lw_a] <= lw_d;
      end
      k_q <= key_mem[nr_a];
      t_q <= tag_mem[nr_a];
      r_q <= rec_mem[nr_a];
      l_q <= link_mem[nr_a];
      if (sw_en) begin
         stk_mem[sw_a] <= sw_d;
      end
      s_q <= stk_mem[sr_a];
   end

   logic [31:0]   quo;
   logic [31:0]   raw;
   logic          have_new;
   logic [PW-1:0] new_node;
   assign req.ready           = (state_ff == cht_pkg::ST_IDLE);
   assign rsp.valid           = rv_ff;
   assign rsp.status          = ost_ff;
   assign rsp.already_present = odup_ff;
   assign rsp.found_record    = ofr_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; key_in = key_ff; tag_in = tag_ff;
      rec_in = rec_ff; rem_in = rem_ff; prod_in = prod_ff; bkt_in = bkt_ff;
      cur_in = cur_ff; prv_in = prv_ff; steps_in = steps_ff;
      rcnt_in = rcnt_ff; fcnt_in = fcnt_ff;
      rv_in = rv_ff; st_in = st_ff; dup_in = dup_ff; fr_in = fr_ff;
      ost_in = ost_ff; odup_in = odup_ff; ofr_in = ofr_ff;
      hw_en = 1'b0; hw_a = bkt_ff; hw_d = NIL; hr_a = bkt_ff;
      nw_en = 1'b0; nw_a = cur_ff[NW-1:0];
      lw_en = 1'b0; lw_a = cur_ff[NW-1:0]; lw_d = l_q;
      nr_a = cur_ff[NW-1:0];
      sw_en = 1'b0; sw_a = rcnt_ff[NW-1:0]; sw_d = cur_ff[NW-1:0];
      sr_a = NW'(rcnt_ff - PW'(1));
      quo = '0; raw = '0;
      have_new = 1'b0; new_node = NIL;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         cht_pkg::ST_CLEAR: begin
            hw_en = 1'b1;
            hw_a  = bkt_ff;
            if (bkt_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = cht_pkg::ST_IDLE;
            end else begin
               bkt_in = bkt_ff + BW'(1);
            end
         end
         cht_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in  = cht_pkg::op_type'(req.operation);
               key_in = req.key; tag_in = req.tag; rec_in = req.record;
               state_in = cht_pkg::ST_HASH;
            end
         end
         cht_pkg::ST_HASH: begin
            prod_in = 64'(key_ff) * 64'(RECIP[31:0]);
            state_in = cht_pkg::ST_MOD;
         end
         cht_pkg::ST_MOD: begin
            // The remainder is below twice the bucket count here.
            quo = 32'(prod_ff >> SH);
            raw = key_ff - quo * 32'(NUM_BUCKETS);
            rem_in = RW'(raw);
            state_in = cht_pkg::ST_HEAD_RD;
         end
         cht_pkg::ST_HEAD_RD: begin
            bkt_in = (rem_ff >= RW'(NUM_BUCKETS)) ? BW'(rem_ff - RW'(NUM_BUCKETS))
                                                  : BW'(rem_ff);
            state_in = cht_pkg::ST_HEAD_WAIT;
         end
         cht_pkg::ST_HEAD_WAIT: begin
            // hr_a = bkt_ff issued here; data next cycle.
            state_in = cht_pkg::ST_NODE_RD;
            cur_in = NIL; prv_in = NIL; steps_in = '0;
         end
         cht_pkg::ST_NODE_RD: begin
            // First pass takes the head; later passes take the link.
            if (steps_ff == '0 && cur_ff == NIL && prv_ff == NIL) begin
               cur_in = hr_q;
            end
            if (op_ff == cht_pkg::OP_NONE) begin
               st_in = 1'b1; dup_in = 1'b0; fr_in = '0;
               state_in = cht_pkg::ST_DONE;
            end else begin
               state_in = cht_pkg::ST_NODE_CHK;
            end
            nr_a = (steps_ff == '0 && cur_ff == NIL && prv_ff == NIL)
                   ? hr_q[NW-1:0] : cur_ff[NW-1:0];
            if (cur_in >= NIL || steps_ff >= (PW+1)'(NUM_NODES)) begin
               cur_in = NIL;
               if (op_ff != cht_pkg::OP_NONE) begin
                  state_in = cht_pkg::ST_UPDATE;
               end
            end
         end
         cht_pkg::ST_NODE_CHK: begin
            if (k_q == key_ff && t_q == tag_ff) begin
               state_in = cht_pkg::ST_UPDATE;
               fr_in = r_q;
            end else begin
               prv_in = cur_ff;
               cur_in = l_q;
               steps_in = steps_ff + (PW+1)'(1);
               state_in = cht_pkg::ST_NODE_RD;
            end
         end
         cht_pkg::ST_UPDATE: begin
            st_in = 1'b1; dup_in = 1'b0;
            state_in = cht_pkg::ST_DONE;
            if (cur_ff != NIL) begin
               // Hit: l_q still holds the node's link.
               unique case (op_ff)
                  cht_pkg::OP_INSERT: begin
                     st_in = 1'b0; dup_in = 1'b1; fr_in = '0;
                  end
                  cht_pkg::OP_DELETE: begin
                     st_in = 1'b0; fr_in = '0;
                     if (prv_ff != NIL) begin
                        lw_en = 1'b1; lw_a = prv_ff[NW-1:0]; lw_d = l_q;
                     end else begin
                        hw_en = 1'b1; hw_d = l_q;
                     end
                     if (rcnt_ff < PW'(NUM_NODES)) begin
                        sw_en = 1'b1;
                        rcnt_in = rcnt_ff + PW'(1);
                     end
                  end
                  cht_pkg::OP_FIND: begin
                     st_in = 1'b0;
                  end
                  default: begin
                     fr_in = '0;
                  end
               endcase
            end else begin
               fr_in = '0;
               if (op_ff == cht_pkg::OP_INSERT) begin
                  if (rcnt_ff != '0) begin
                     have_new = 1'b1; new_node = {1'b0, s_q};
                     rcnt_in = rcnt_ff - PW'(1);
                  end else if (fcnt_ff < PW'(NUM_NODES)) begin
                     have_new = 1'b1; new_node = fcnt_ff;
                     fcnt_in = fcnt_ff + PW'(1);
                  end
                  if (have_new) begin
                     st_in = 1'b0;
                     nw_en = 1'b1; nw_a = new_node[NW-1:0];
                     lw_en = 1'b1; lw_a = new_node[NW-1:0]; lw_d = hr_q;
                     hw_en = 1'b1; hw_d = new_node;
                  end
               end
            end
         end
         cht_pkg::ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               ost_in = st_ff; odup_in = dup_ff; ofr_in = fr_ff;
               state_in = cht_pkg::ST_IDLE;
            end
         end
         default: state_in = cht_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cht_pkg::ST_CLEAR;
         bkt_ff <= '0; rcnt_ff <= '0; fcnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bkt_ff <= bkt_in; rcnt_ff <= rcnt_in; fcnt_ff <= fcnt_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; key_ff <= key_in; tag_ff <= tag_in; rec_ff <= rec_in;
      rem_ff <= rem_in; prod_ff <= prod_in; cur_ff <= cur_in; prv_ff <= prv_in;
      steps_ff <= steps_in; st_ff <= st_in; dup_ff <= dup_in; fr_ff <= fr_in;
      ost_ff <= ost_in; odup_ff <= odup_in; ofr_ff <= ofr_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == cht_pkg::ST_HASH)
      else $error("item accepted outside idle");
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= fcnt_ff) else $error("free stack exceeds allocated nodes");
   a_dup_ok: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && odup_ff) |-> !ost_ff) else $error("duplicate flagged with failure");
endmodule

/* sim/tb_chained_hash_table_engine.sv */
// Self-checking testbench for the chained hash table engine: a directed table, then random
// insert/delete/find traffic with random stalls on both channels. Depends on cht_pkg and cht_if.sv.
`timescale 1ns / 1ps
module tb_chained_hash_table_engine;
   localparam int NBUCK     = cht_pkg::NumBucketsDefault;
   localparam int NNODE     = cht_pkg::NumNodesDefault;
   localparam int NIL       = NNODE;
   localparam int RAND_ITEMS = 1850;
   localparam longint CYCLE_LIMIT = 10_000_000;

   typedef struct packed {
      logic        status;
      logic        already_present;
      logic [31:0] found_record;
   } answer_t;

   typedef struct {
      cht_pkg::op_type op;
      logic [31:0]     key;
      logic [31:0]     tag;
      logic [31:0]     record;
      bit              typed;
      answer_t         answer;
   } stim_row_t;

   typedef struct {
      bit      typed;
      answer_t answer;
   } pending_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cht_req_if req ();
   cht_rsp_if rsp ();

   chained_hash_table_engine i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #6 clock = ~clock;

   // Shadow copy of the table.
   int unsigned tbl_head  [NBUCK];
   logic [31:0] tbl_key   [NNODE];
   logic [31:0] tbl_tag   [NNODE];
   logic [31:0] tbl_rec   [NNODE];
   int unsigned tbl_link  [NNODE];
   int unsigned free_stack[NNODE];
   int unsigned free_count;
   int unsigned fresh_count;

   answer_t     expected_q[$];
   pending_t    typed_q[$];
   logic [31:0] pair_keys[$];
   logic [31:0] pair_tags[$];
   int          errors;
   int          accepted;
   longint      cycles;

   function automatic int unsigned locate(int unsigned b, logic [31:0] k, logic [31:0] t,
                                          output int unsigned prev);
      int unsigned cur;
      int unsigned steps;
      cur = tbl_head[b];
      prev = NIL;
      steps = 0;
      while (cur < NIL && steps < NNODE) begin
         if (tbl_key[cur] == k && tbl_tag[cur] == t) return cur;
         prev = cur;
         cur = tbl_link[cur];
         steps++;
      end
      prev = NIL;
      return NIL;
   endfunction

   function automatic answer_t apply_op(cht_pkg::op_type op, logic [31:0] k, logic [31:0] t,
                                        logic [31:0] r);
      int unsigned b;
      int unsigned prev;
      int unsigned hit;
      int unsigned n;
      answer_t a;
      b = k % NBUCK;
      a = '{status: 1'b1, already_present: 1'b0, found_record: '0};
      if (op == cht_pkg::OP_NONE) return a;
      hit = locate(b, k, t, prev);
      case (op)
         cht_pkg::OP_INSERT: begin
            if (hit < NIL) begin
               a.status = 1'b0;
               a.already_present = 1'b1;
            end else begin
               n = NIL;
               if (free_count > 0) begin
                  free_count--;
                  n = free_stack[free_count];
               end else if (fresh_count < NNODE) begin
                  n = fresh_count;
                  fresh_count++;
               end
               if (n < NIL) begin
                  tbl_key[n] = k;
                  tbl_tag[n] = t;
                  tbl_rec[n] = r;
                  tbl_link[n] = tbl_head[b];
                  tbl_head[b] = n;
                  a.status = 1'b0;
               end
            end
         end
         cht_pkg::OP_DELETE: begin
            if (hit < NIL) begin
               if (prev < NIL) tbl_link[prev] = tbl_link[hit];
               else tbl_head[b] = tbl_link[hit];
               if (free_count < NNODE) begin
                  free_stack[free_count] = hit;
                  free_count++;
               end
               a.status = 1'b0;
            end
         end
         default: begin
            if (hit < NIL) begin
               a.status = 1'b0;
               a.found_record = tbl_rec[hit];
            end
         end
      endcase
      return a;
   endfunction

   // Directed rows; typed answers only where they are obvious.
   stim_row_t dir_rows[22] = '{
      '{cht_pkg::OP_FIND,   32'h0,        32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_DELETE, 32'h0,        32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_NONE,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_INSERT, 32'h0,        32'h0,        32'h0,        1, '{1'b0, 1'b0, 32'h0}},
      '{cht_pkg::OP_FIND,   32'h0,        32'h0,        32'h0,        1, '{1'b0, 1'b0, 32'h0}},
      '{cht_pkg::OP_INSERT, 32'h0,        32'h0,        32'h12345678, 1, '{1'b0, 1'b1, 32'h0}},
      '{cht_pkg::OP_FIND,   32'h0,        32'h0,        32'h0,        1, '{1'b0, 1'b0, 32'h0}},
      '{cht_pkg::OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{1'b0, 1'b0, 32'h0}},
      '{cht_pkg::OP_FIND,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,        1,
        '{1'b0, 1'b0, 32'hFFFFFFFF}},
      '{cht_pkg::OP_INSERT, 32'd251,      32'h0,        32'hA5A5A5A5, 0, '0},
      '{cht_pkg::OP_INSERT, 32'h0,        32'h1,        32'h5A5A5A5A, 0, '0},
      '{cht_pkg::OP_FIND,   32'd251,      32'h0,        32'h0,        0, '0},
      '{cht_pkg::OP_DELETE, 32'd251,      32'h0,        32'h0,        0, '0},
      '{cht_pkg::OP_FIND,   32'd251,      32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_FIND,   32'h0,        32'h1,        32'h0,        0, '0},
      '{cht_pkg::OP_DELETE, 32'h0,        32'h1,        32'h0,        0, '0},
      '{cht_pkg::OP_DELETE, 32'h0,        32'h0,        32'h0,        0, '0},
      '{cht_pkg::OP_FIND,   32'h0,        32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_INSERT, 32'd502,      32'h7,        32'hDEADBEEF, 0, '0},
      '{cht_pkg::OP_FIND,   32'd502,      32'h7,        32'h0,        0, '0},
      '{cht_pkg::OP_NONE,   32'h0,        32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}},
      '{cht_pkg::OP_FIND,   32'hFFFFFFFF, 32'h0,        32'h0,        1, '{1'b1, 1'b0, 32'h0}}
   };

   function automatic int unsigned pick_gap(bit quiet);
      int unsigned p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 90);
   endfunction

   task automatic send_item(cht_pkg::op_type op, logic [31:0] k, logic [31:0] t,
                            logic [31:0] r, bit typed, answer_t answer, bit quiet);
      int unsigned gap;
      gap = pick_gap(quiet);
      typed_q.push_back('{typed, answer});
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.key       <= k;
      req.tag       <= t;
      req.record    <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic [31:0] make_key();
      int unsigned hot;
      if ($urandom_range(0, 99) < 45) begin
         case ($urandom_range(0, 2))
            0: hot = 0;
            1: hot = 5;
            default: hot = NBUCK - 1;
         endcase
         return hot + NBUCK * $urandom_range(0, 17_000_000);
      end
      return $urandom;
   endfunction

   // Accepted items update the shadow table; responses are checked against the oldest one.
   always @(posedge clock) begin
      pending_t  pend;
      answer_t   pred;
      answer_t   want;
      cycles <= cycles + 1;
      if (!reset && req.valid && req.ready) begin
         pred = apply_op(cht_pkg::op_type'(req.operation), req.key, req.tag, req.record);
         pend = typed_q.pop_front();
         expected_q.push_back(pend.typed ? pend.answer : pred);
         accepted <= accepted + 1;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected: status %0b dup %0b rec %h",
                     $time, rsp.status, rsp.already_present, rsp.found_record);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp.status !== want.status) begin
               $display("%0t: status expected %0b actual %0b", $time, want.status, rsp.status);
               errors++;
            end
            if (rsp.already_present !== want.already_present) begin
               $display("%0t: already_present expected %0b actual %0b", $time,
                        want.already_present, rsp.already_present);
               errors++;
            end
            if (rsp.found_record !== want.found_record) begin
               $display("%0t: found_record expected %h actual %h", $time,
                        want.found_record, rsp.found_record);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Response side: random stalls, quiet stretches, and one long hold-off.
   initial begin
      int unsigned stall;
      int unsigned hold;
      bit held;
      stall = 0;
      hold = 0;
      held = 0;
      rsp.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && accepted >= 700) begin
            held = 1;
            hold = 400;
         end
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            hold--;
         end else if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            stall = pick_gap((cycles / 3000) % 4 == 1);
            rsp.ready <= (stall == 0);
            if (stall > 0) stall--;
         end
         @(posedge clock);
      end
   end

   initial begin
      cht_pkg::op_type op;
      logic [31:0] k;
      logic [31:0] t;
      logic [31:0] r;
      int unsigned p;
      int unsigned idx;
      int unsigned wait_cycles;
      bit          quiet;
      for (int i = 0; i < NBUCK; i++) tbl_head[i] = NIL;
      free_count = 0;
      fresh_count = 0;
      errors = 0;
      accepted = 0;
      cycles = 0;
      req.valid = 1'b0;
      req.operation = cht_pkg::OP_NONE;
      req.key = '0;
      req.tag = '0;
      req.record = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].tag, dir_rows[i].record,
                   dir_rows[i].typed, dir_rows[i].answer, 1'b0);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         quiet = ((i / 150) % 4 == 2);
         p = $urandom_range(0, 99);
         // Fill the pool first, then drain it, then mixed traffic.
         if (i < 330) begin
            op = (p < 80) ? cht_pkg::OP_INSERT : (p < 90) ? cht_pkg::OP_FIND :
                 (p < 97) ? cht_pkg::OP_DELETE : cht_pkg::OP_NONE;
         end else if (i < 700) begin
            op = (p < 60) ? cht_pkg::OP_DELETE : (p < 75) ? cht_pkg::OP_INSERT :
                 (p < 97) ? cht_pkg::OP_FIND : cht_pkg::OP_NONE;
         end else begin
            op = (p < 35) ? cht_pkg::OP_INSERT : (p < 65) ? cht_pkg::OP_DELETE :
                 (p < 96) ? cht_pkg::OP_FIND : cht_pkg::OP_NONE;
         end
         r = $urandom;
         if (pair_keys.size() > 0 &&
             $urandom_range(0, 99) < ((op == cht_pkg::OP_INSERT) ? 15 : 75)) begin
            idx = $urandom_range(0, pair_keys.size() - 1);
            k = pair_keys[idx];
            t = pair_tags[idx];
         end else begin
            k = make_key();
            t = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
            if (op == cht_pkg::OP_INSERT) begin
               pair_keys.push_back(k);
               pair_tags.push_back(t);
               if (pair_keys.size() > 400) begin
                  void'(pair_keys.pop_front());
                  void'(pair_tags.pop_front());
               end
            end
         end
         if (op == cht_pkg::OP_NONE) begin
            k = $urandom;
            t = $urandom;
         end
         send_item(op, k, t, r, 1'b0, '0, quiet);
      end
      req.valid <= 1'b0;

      while (expected_q.size() > 0) @(posedge clock);
      wait_cycles = 600;
      repeat (wait_cycles) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: outstanding responses expected 0 actual %0d", $time,
                  expected_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
